// ----- rtl/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants for the top-k nonzero index selector
// Sizes, widths and the entry/command records passed along the cell chain.
// ----------------------------------------------------------------------------
package tks_pkg;

    // Depth of the kept list and the longest list of layers that is indexed
    localparam int TOP_K      = 16;
    localparam int MAX_LAYERS = 256;
    localparam int OUT_LIMIT  = 16;

    // Field widths
    localparam int SIZE_W      = 48;
    localparam int PICK_IDX_W  = 8;
    localparam int PICK_CNT_W  = 5;
    localparam int NEXT_IDX_W  = $clog2(MAX_LAYERS + 1);
    localparam int ENTRY_IDX_W = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS) : 1;
    localparam int COUNT_W     = $clog2(TOP_K + 1);
    localparam int CMP_W       = (COUNT_W > PICK_CNT_W) ? COUNT_W : PICK_CNT_W;

    // Most picks a list may return
    localparam int PICK_LIMIT  = (TOP_K < OUT_LIMIT) ? TOP_K : OUT_LIMIT;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [PICK_CNT_W-1:0] PICK_COUNT_RESET = PICK_CNT_W'(16);
    localparam logic REG_PICK_COUNT = 1'b0;   // word index of pick_count

    // Control sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } tks_state_t;

    // One kept entry
    typedef struct packed {
        logic                   valid;
        logic [SIZE_W-1:0]      size;
        logic [ENTRY_IDX_W-1:0] index;
    } tks_entry_t;

    // Broadcast command to every cell of the chain
    typedef struct packed {
        logic                   ins_en;
        logic                   shift_up;
        logic                   clear;
        logic [SIZE_W-1:0]      size;
        logic [ENTRY_IDX_W-1:0] index;
    } tks_cmd_t;

endpackage

// ----- rtl/tks_cell.sv -----
// ----------------------------------------------------------------------------
// tks_cell: one slot of the sorted insertion chain
// Holds one entry, compares it with the broadcast size, and takes its
// neighbor's entry on insert (from above) or on drain (from below).
// ----------------------------------------------------------------------------
module tks_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tks_pkg::tks_cmd_t   cmd,
    input  tks_pkg::tks_entry_t prev_entry,
    input  logic                prev_ins,
    input  tks_pkg::tks_entry_t next_entry,
    output tks_pkg::tks_entry_t entry,
    output logic                ins
);
    import tks_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [SIZE_W-1:0]      size_reg;
    logic [SIZE_W-1:0]      size_next;
    logic [ENTRY_IDX_W-1:0] index_reg;
    logic [ENTRY_IDX_W-1:0] index_next;

    // New size lands at or above this slot: slot empty or strictly smaller
    assign ins = !valid_reg || (cmd.size > size_reg);

    assign entry.valid = valid_reg;
    assign entry.size  = size_reg;
    assign entry.index = index_reg;

    // Select the slot's next content
    always_comb
    begin
        valid_next = valid_reg;
        size_next  = size_reg;
        index_next = index_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.shift_up)
        begin
            valid_next = next_entry.valid;
            size_next  = next_entry.size;
            index_next = next_entry.index;
        end
        else if (cmd.ins_en)
        begin
            if (prev_ins)
            begin
                valid_next = prev_entry.valid;
                size_next  = prev_entry.size;
                index_next = prev_entry.index;
            end
            else if (ins)
            begin
                valid_next = 1'b1;
                size_next  = cmd.size;
                index_next = cmd.index;
            end
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        index_reg <= index_next;
    end

endmodule

// ----- rtl/top_k_nonzero_index_select_unit.sv -----
// Non-last item: taken while idle, and the next item may follow the cycle after.
// Last item: the list drains from the head cell, one result beat per cycle unless
// out_ready stalls (n beats, or one empty beat), loaded once the state is ST_EMIT.
// Input ready drops from the last item until the final beat is loaded.
// Reset (rst_n low, asynchronous) empties the chain and sets pick_count to 16.
// ----------------------------------------------------------------------------
// top_k_nonzero_index_select_unit: stable top-k selector over layer sizes
// A row of TOP_K cells keeps the largest nonzero sizes in descending order
// (earlier index first on ties) and drains them when the list ends.
// ----------------------------------------------------------------------------
module top_k_nonzero_index_select_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tks_pkg::SIZE_W-1:0]         layer_size,
    input  logic                               last_layer,
    // result items
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tks_pkg::PICK_IDX_W-1:0]     picked_index,
    output logic [tks_pkg::SIZE_W-1:0]         picked_size,
    output logic                               pick_valid,
    output logic                               list_overflow,
    output logic                               last_pick,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tks_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tks_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tks_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import tks_pkg::*;

    tks_state_t             state_reg;
    tks_state_t             state_next;
    logic [PICK_CNT_W-1:0]  pick_count_reg;
    logic [COUNT_W-1:0]     kept_count_reg;
    logic [COUNT_W-1:0]     kept_count_next;
    logic [NEXT_IDX_W-1:0]  next_index_reg;
    logic [NEXT_IDX_W-1:0]  next_index_next;
    logic                   overflow_seen_reg;
    logic                   overflow_seen_next;
    logic [PICK_CNT_W-1:0]  remaining_reg;
    logic [PICK_CNT_W-1:0]  remaining_next;

    logic                   out_valid_reg;
    logic [PICK_IDX_W-1:0]  picked_index_reg;
    logic [SIZE_W-1:0]      picked_size_reg;
    logic                   pick_valid_reg;
    logic                   list_overflow_reg;
    logic                   last_pick_reg;

    logic                   in_beat;
    logic                   at_limit;
    logic                   emit_load;
    logic                   final_load;
    logic                   cfg_write;
    logic [CMP_W-1:0]       pick_clamped;
    logic [CMP_W-1:0]       pick_total;

    tks_cmd_t               cmd;
    tks_entry_t             entries [TOP_K];
    logic                   ins_flags [TOP_K];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_count_reg <= PICK_COUNT_RESET;
        end
        else if (cfg_write && (paddr[APB_ADDR_W-1] == REG_PICK_COUNT))
        begin
            pick_count_reg <= pwdata[PICK_CNT_W-1:0];
        end
    end

    // Read back pick_count at its word, zero elsewhere
    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_PICK_COUNT)
        begin
            prdata = APB_DATA_W'(pick_count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign in_beat  = in_valid && in_ready;
    assign at_limit = (next_index_reg == NEXT_IDX_W'(MAX_LAYERS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && last_layer)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (final_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        emit_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EMIT:
            begin
                emit_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Final beat is the empty result or the last real pick
    assign final_load = emit_load && (remaining_reg <= PICK_CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // List bookkeeping
    // ------------------------------------------------------------------
    // Clamp the requested count, then to the entries held after this insert
    always_comb
    begin
        pick_clamped = CMP_W'(pick_count_reg);
        if (pick_clamped > CMP_W'(PICK_LIMIT))
        begin
            pick_clamped = CMP_W'(PICK_LIMIT);
        end
        pick_total = pick_clamped;
        if (pick_total > CMP_W'(kept_count_next))
        begin
            pick_total = CMP_W'(kept_count_next);
        end
    end

    always_comb
    begin
        kept_count_next    = kept_count_reg;
        next_index_next    = next_index_reg;
        overflow_seen_next = overflow_seen_reg;
        remaining_next     = remaining_reg;
        if (in_beat)
        begin
            if (at_limit)
            begin
                overflow_seen_next = 1'b1;
            end
            else
            begin
                next_index_next = next_index_reg + NEXT_IDX_W'(1);
                if (cmd.ins_en && (kept_count_reg != COUNT_W'(TOP_K)))
                begin
                    kept_count_next = kept_count_reg + COUNT_W'(1);
                end
            end
        end
        if (in_beat && last_layer)
        begin
            remaining_next = PICK_CNT_W'(pick_total);
        end
        else if (final_load)
        begin
            kept_count_next    = '0;
            next_index_next    = '0;
            overflow_seen_next = 1'b0;
            remaining_next     = '0;
        end
        else if (emit_load)
        begin
            remaining_next = remaining_reg - PICK_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg    <= '0;
            next_index_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            remaining_reg     <= '0;
        end
        else
        begin
            kept_count_reg    <= kept_count_next;
            next_index_reg    <= next_index_next;
            overflow_seen_reg <= overflow_seen_next;
            remaining_reg     <= remaining_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    // Broadcast insert on nonzero in-range sizes, advance on drain, drop at end
    always_comb
    begin
        cmd.ins_en   = in_beat && !at_limit && (layer_size != '0);
        cmd.shift_up = emit_load && !final_load;
        cmd.clear    = final_load;
        cmd.size     = layer_size;
        cmd.index    = ENTRY_IDX_W'(next_index_reg);
    end

    for (genvar i = 0; i < TOP_K; i++)
    begin : g_cell
        tks_entry_t prev_e;
        tks_entry_t next_e;
        logic       prev_i;

        if (i == 0)
        begin : g_head
            assign prev_e = '0;
            assign prev_i = 1'b0;
        end
        else
        begin : g_body
            assign prev_e = entries[i-1];
            assign prev_i = ins_flags[i-1];
        end

        if (i == TOP_K - 1)
        begin : g_tail
            assign next_e = '0;
        end
        else
        begin : g_inner
            assign next_e = entries[i+1];
        end

        tks_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_entry (prev_e),
            .prev_ins   (prev_i),
            .next_entry (next_e),
            .entry      (entries[i]),
            .ins        (ins_flags[i])
        );
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the head cell, or the empty result when nothing is picked
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            list_overflow_reg <= overflow_seen_reg;
            last_pick_reg     <= (remaining_reg <= PICK_CNT_W'(1));
            if (remaining_reg == '0)
            begin
                picked_index_reg <= '0;
                picked_size_reg  <= '0;
                pick_valid_reg   <= 1'b0;
            end
            else
            begin
                picked_index_reg <= PICK_IDX_W'(entries[0].index);
                picked_size_reg  <= entries[0].size;
                pick_valid_reg   <= 1'b1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign picked_index  = picked_index_reg;
    assign picked_size   = picked_size_reg;
    assign pick_valid    = pick_valid_reg;
    assign list_overflow = list_overflow_reg;
    assign last_pick     = last_pick_reg;

endmodule

// ----- rtl/tks_checker.sv -----
// ----------------------------------------------------------------------------
// tks_checker: port-level checks for the top-k selector
// Watches the handshakes and result beats of the top level.
// ----------------------------------------------------------------------------
module tks_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           last_layer,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [tks_pkg::PICK_IDX_W-1:0] picked_index,
    input  logic [tks_pkg::SIZE_W-1:0]     picked_size,
    input  logic                           pick_valid,
    input  logic                           last_pick
);
    import tks_pkg::*;

    // Block stops taking items once a list ends
    a_busy_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_layer) |=> !in_ready
    ) else $error("input ready after the last item of a list");

    // An empty result is always marked as the final beat
    a_empty_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !pick_valid) |-> last_pick
    ) else $error("empty result not marked last");

    // An empty result carries zero index and size
    a_empty_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !pick_valid) |-> ((picked_size == '0) && (picked_index == '0))
    ) else $error("empty result carries a pick");

    // A real pick never has zero size
    a_pick_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && pick_valid) |-> (picked_size != '0)
    ) else $error("zero size picked");

    // Stalled result beat holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(picked_size) && $stable(last_pick))
    ) else $error("result beat changed while stalled");

endmodule

bind top_k_nonzero_index_select_unit tks_checker u_tks_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_layer   (last_layer),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .picked_index (picked_index),
    .picked_size  (picked_size),
    .pick_valid   (pick_valid),
    .last_pick    (last_pick)
);
